// ===== sv/alr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the adaptive linear resampler
// widths, codes, controller commands and datapath status
// ----------------------------------------------------------------------------
package alr_pkg;

  // window geometry (power of two so ring pointers wrap by truncation)
  localparam int WIN_DEPTH = 16;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int CNT_W     = WIN_AW + 1;

  // fixed point formats
  localparam int FRAC_BITS = 16;
  localparam int PHASE_W   = FRAC_BITS;
  localparam int STEP_W    = FRAC_BITS + 2;
  localparam int ADV_W     = STEP_W + 1;
  localparam int PASS_W    = ADV_W - FRAC_BITS;

  // field widths
  localparam int OP_W      = 2;
  localparam int FILL_W    = 16;
  localparam int SAMPLE_W  = 17;
  localparam int WORD_W    = 2 * SAMPLE_W;
  localparam int PCM_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int NOM_W     = 18;
  localparam int THR_W     = 16;
  localparam int LIM_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // correction divider and step multiplier
  localparam int DIV_QW    = LIM_W + 1;
  localparam int DIV_IW    = $clog2(DIV_QW);
  localparam int NUM_W     = THR_W + 16;
  localparam int DEN_W     = THR_W + 5;
  localparam int TRIAL_W   = DEN_W + DIV_QW - 1;
  localparam int FACTOR_W  = 17;
  localparam int PROD_W    = NOM_W + FACTOR_W;
  localparam int SUM_W     = SAMPLE_W + 2;
  localparam int IPROD_W   = SAMPLE_W + 1 + PHASE_W + 1;

  localparam logic [FACTOR_W-1:0]   UNITY    = FACTOR_W'(65536);
  localparam logic [STEP_W-1:0]     STEP_MAX = '1;
  localparam logic signed [SUM_W-1:0] CLAMP_POS = SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] CLAMP_NEG = -SUM_W'(32768);

  // register reset values
  localparam logic [NOM_W-1:0]  NOM_RESET  = NOM_W'(71306);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(4800);
  localparam logic [LIM_W-1:0]  LIM_RESET  = LIM_W'(1311);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(71306);

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_BLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NORMAL   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PREBUF   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERRUN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MUTED    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_MUL,
    S_STEP,
    S_CAP_A,
    S_CAP_B,
    S_INTERP,
    S_FINISH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                load_item;
    logic                push;
    logic                bs_enter;
    logic                step_nominal;
    logic                div_start;
    logic                div_iter;
    logic                mul;
    logic                step_write;
    logic                silence;
    logic [STATUS_W-1:0] silence_code;
    logic                underrun;
    logic                rd_next;
    logic                cap_a;
    logic                cap_b;
    logic                interp;
    logic                finish;
    logic                emit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            prebuffered;
    logic            empty;
    logic            block_hold;
    logic            thr_zero;
    logic            div_last;
    logic            slot_free;
  } stat_t;

endpackage

// ===== sv/alr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_in_if: request channel of the resampler
// valid/ready handshake with push, block start and output tick payload
// ----------------------------------------------------------------------------
interface alr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [alr_pkg::OP_W-1:0]             operation;
  logic [alr_pkg::FILL_W-1:0]           fill_level;
  logic signed [alr_pkg::SAMPLE_W-1:0]  sample_left;
  logic signed [alr_pkg::SAMPLE_W-1:0]  sample_right;
  logic                                 paused;

  modport source (
    output valid, operation, fill_level, sample_left, sample_right, paused,
    input  ready
  );
  modport sink (
    input  valid, operation, fill_level, sample_left, sample_right, paused,
    output ready
  );
endinterface

// ===== sv/alr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_out_if: result channel of the resampler
// valid/ready handshake carrying one stereo pcm pair and a status code
// ----------------------------------------------------------------------------
interface alr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [alr_pkg::PCM_W-1:0]    out_left;
  logic signed [alr_pkg::PCM_W-1:0]    out_right;
  logic [alr_pkg::STATUS_W-1:0]        status;

  modport source (
    output valid, out_left, out_right, status,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_right, status,
    output ready
  );
endinterface

// ===== sv/alr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_cfg_if: configuration write channel
// valid/ready handshake carrying a register index and write data
// ----------------------------------------------------------------------------
interface alr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [alr_pkg::CFG_IDX_W-1:0]     index;
  logic [alr_pkg::CFG_DAT_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== sv/alr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module alr_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/alr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_ctrl: resampler sequencer
// steps each request through dispatch, correction division or interpolation
// ----------------------------------------------------------------------------
module alr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  alr_pkg::stat_t stat,
  output alr_pkg::cmd_t  cmd
);

  alr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      alr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = alr_pkg::S_DISPATCH;
        end
      end
      alr_pkg::S_DISPATCH: begin
        state_next = alr_pkg::S_IDLE;
        case (stat.op)
          alr_pkg::OP_PUSH: begin
            cmd.push = 1'b1;
          end
          alr_pkg::OP_BLOCK: begin
            if (!stat.block_hold) begin
              cmd.bs_enter = 1'b1;
              if (stat.thr_zero) begin
                cmd.step_nominal = 1'b1;
              end else begin
                cmd.div_start = 1'b1;
                state_next    = alr_pkg::S_DIV;
              end
            end
          end
          alr_pkg::OP_TICK: begin
            if (!stat.prebuffered) begin
              cmd.silence      = 1'b1;
              cmd.silence_code = alr_pkg::ST_PREBUF;
              state_next       = alr_pkg::S_EMIT;
            end else if (stat.empty) begin
              cmd.silence      = 1'b1;
              cmd.silence_code = alr_pkg::ST_UNDERRUN;
              cmd.underrun     = 1'b1;
              state_next       = alr_pkg::S_EMIT;
            end else begin
              // head read issued this cycle
              state_next = alr_pkg::S_CAP_A;
            end
          end
          default: begin
            state_next = alr_pkg::S_IDLE;
          end
        endcase
      end
      alr_pkg::S_DIV: begin
        cmd.div_iter = 1'b1;
        if (stat.div_last) begin
          state_next = alr_pkg::S_MUL;
        end
      end
      alr_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = alr_pkg::S_STEP;
      end
      alr_pkg::S_STEP: begin
        cmd.step_write = 1'b1;
        state_next     = alr_pkg::S_IDLE;
      end
      alr_pkg::S_CAP_A: begin
        cmd.cap_a   = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = alr_pkg::S_CAP_B;
      end
      alr_pkg::S_CAP_B: begin
        cmd.cap_b  = 1'b1;
        state_next = alr_pkg::S_INTERP;
      end
      alr_pkg::S_INTERP: begin
        cmd.interp = 1'b1;
        state_next = alr_pkg::S_FINISH;
      end
      alr_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = alr_pkg::S_EMIT;
      end
      alr_pkg::S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = alr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = alr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/alr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_dp: resampler datapath
// window ring, phase and step state, correction divider, interpolator, output
// ----------------------------------------------------------------------------
module alr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  alr_pkg::cmd_t                       cmd,
  output alr_pkg::stat_t                      stat,
  input  logic [alr_pkg::OP_W-1:0]            operation,
  input  logic [alr_pkg::FILL_W-1:0]          fill_level,
  input  logic signed [alr_pkg::SAMPLE_W-1:0] sample_left,
  input  logic signed [alr_pkg::SAMPLE_W-1:0] sample_right,
  input  logic                                paused,
  input  logic                                cfg_valid,
  input  logic [alr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [alr_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [alr_pkg::PCM_W-1:0]    out_left,
  output logic signed [alr_pkg::PCM_W-1:0]    out_right,
  output logic [alr_pkg::STATUS_W-1:0]        out_status
);

  // clamp to +-1.0, then move one lsb toward zero
  function automatic logic signed [alr_pkg::PCM_W-1:0] to_pcm(
    input logic signed [alr_pkg::SUM_W-1:0] s
  );
    logic signed [alr_pkg::SUM_W-1:0] c;
    logic signed [alr_pkg::SUM_W-1:0] r;
    c = s;
    if (s > alr_pkg::CLAMP_POS) begin
      c = alr_pkg::CLAMP_POS;
    end else if (s < alr_pkg::CLAMP_NEG) begin
      c = alr_pkg::CLAMP_NEG;
    end
    if (c > 0) begin
      r = c - 2'sd1;
    end else if (c < 0) begin
      r = c + 2'sd1;
    end else begin
      r = '0;
    end
    return r[alr_pkg::PCM_W-1:0];
  endfunction

  // latched request
  logic [alr_pkg::OP_W-1:0]            op_q;
  logic [alr_pkg::FILL_W-1:0]          fill_q;
  logic signed [alr_pkg::SAMPLE_W-1:0] sl_q;
  logic signed [alr_pkg::SAMPLE_W-1:0] sr_q;
  logic                                paused_q;

  // configuration
  logic [alr_pkg::NOM_W-1:0] nominal;
  logic [alr_pkg::THR_W-1:0] thr;
  logic [alr_pkg::LIM_W-1:0] lim;
  logic                      mute;

  // resampler state
  logic [alr_pkg::WIN_AW-1:0]  head;
  logic [alr_pkg::CNT_W-1:0]   count;
  logic [alr_pkg::PHASE_W-1:0] phase;
  logic [alr_pkg::STEP_W-1:0]  step;
  logic                        prebuffered;

  // divider and step multiplier
  logic [alr_pkg::NUM_W-1:0]    rem;
  logic [alr_pkg::DIV_QW-1:0]   quo;
  logic [alr_pkg::DIV_IW-1:0]   bit_idx;
  logic                         neg;
  logic [alr_pkg::PROD_W-1:0]   prod_step;

  // interpolation
  logic signed [alr_pkg::SAMPLE_W-1:0] a_l, a_r, b_l, b_r;
  logic signed [alr_pkg::IPROD_W-1:0]  prod_l, prod_r;
  logic signed [alr_pkg::PCM_W-1:0]    pend_left, pend_right;
  logic [alr_pkg::STATUS_W-1:0]        pend_status;

  // window memory
  logic                       full;
  logic                       ram_we;
  logic [alr_pkg::WIN_AW-1:0] ram_waddr, ram_raddr;
  logic [alr_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  assign full      = (count == alr_pkg::CNT_W'(alr_pkg::WIN_DEPTH));
  assign ram_we    = cmd.push && !full;
  assign ram_waddr = head + count[alr_pkg::WIN_AW-1:0];
  assign ram_wdata = {sl_q, sr_q};
  assign ram_raddr = cmd.rd_next ? head + 1'b1 : head;

  alr_ram #(
    .WIDTH (alr_pkg::WORD_W),
    .DEPTH (alr_pkg::WIN_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // correction divider operands
  logic [alr_pkg::THR_W-1:0]   diff_mag;
  logic [alr_pkg::NUM_W-1:0]   num;
  logic [alr_pkg::DEN_W-1:0]   den;
  logic [alr_pkg::TRIAL_W-1:0] trial;
  logic                        fits;

  assign diff_mag = (fill_q >= thr) ? fill_q - thr : thr - fill_q;
  assign num      = {diff_mag, 16'd0};
  assign den      = {1'b0, thr, 4'd0} + {3'd0, thr, 2'd0};
  assign trial    = {{(alr_pkg::DIV_QW-1){1'b0}}, den} << bit_idx;
  assign fits     = {{(alr_pkg::TRIAL_W-alr_pkg::NUM_W){1'b0}}, rem} >= trial;

  // clamp the correction and form the step factor
  logic [alr_pkg::LIM_W-1:0]    mag;
  logic [alr_pkg::FACTOR_W-1:0] factor;
  logic [alr_pkg::ADV_W-1:0]    step_raw;

  assign mag      = (quo > {1'b0, lim}) ? lim : quo[alr_pkg::LIM_W-1:0];
  assign factor   = neg ? alr_pkg::UNITY - alr_pkg::FACTOR_W'(mag)
                        : alr_pkg::UNITY + alr_pkg::FACTOR_W'(mag);
  assign step_raw = prod_step[alr_pkg::PROD_W-1:16];

  // interpolation terms
  logic signed [alr_pkg::SAMPLE_W:0]    diff_l, diff_r;
  logic signed [alr_pkg::PHASE_W:0]     frac;
  logic signed [alr_pkg::IPROD_W-1:0]   sh_l, sh_r;
  logic signed [alr_pkg::SUM_W-1:0]     sum_l, sum_r;
  logic signed [alr_pkg::SAMPLE_W-1:0]  rd_l, rd_r;

  assign rd_l   = ram_rdata[alr_pkg::WORD_W-1:alr_pkg::SAMPLE_W];
  assign rd_r   = ram_rdata[alr_pkg::SAMPLE_W-1:0];
  assign diff_l = {b_l[alr_pkg::SAMPLE_W-1], b_l} - {a_l[alr_pkg::SAMPLE_W-1], a_l};
  assign diff_r = {b_r[alr_pkg::SAMPLE_W-1], b_r} - {a_r[alr_pkg::SAMPLE_W-1], a_r};
  assign frac   = {1'b0, phase};
  assign sh_l   = prod_l >>> alr_pkg::FRAC_BITS;
  assign sh_r   = prod_r >>> alr_pkg::FRAC_BITS;
  assign sum_l  = {{2{a_l[alr_pkg::SAMPLE_W-1]}}, a_l} + sh_l[alr_pkg::SUM_W-1:0];
  assign sum_r  = {{2{a_r[alr_pkg::SAMPLE_W-1]}}, a_r} + sh_r[alr_pkg::SUM_W-1:0];

  // phase advance and pop count
  logic [alr_pkg::ADV_W-1:0]  adv;
  logic [alr_pkg::PASS_W-1:0] npass, npop;
  logic                       mute_now;

  assign adv      = {{(alr_pkg::ADV_W-alr_pkg::PHASE_W){1'b0}}, phase}
                  + {1'b0, step};
  assign npass    = adv[alr_pkg::ADV_W-1:alr_pkg::FRAC_BITS];
  assign npop     = (alr_pkg::CNT_W'(npass) > count) ? count[alr_pkg::PASS_W-1:0] : npass;
  assign mute_now = mute && paused_q;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q     <= operation;
      fill_q   <= fill_level;
      sl_q     <= sample_left;
      sr_q     <= sample_right;
      paused_q <= paused;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal <= alr_pkg::NOM_RESET;
      thr     <= alr_pkg::THR_RESET;
      lim     <= alr_pkg::LIM_RESET;
      mute    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        alr_pkg::REG_NOMINAL: nominal <= cfg_data;
        alr_pkg::REG_THRESH:  thr     <= cfg_data[alr_pkg::THR_W-1:0];
        alr_pkg::REG_LIMIT:   lim     <= cfg_data[alr_pkg::LIM_W-1:0];
        alr_pkg::REG_MUTE:    mute    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // window pointers, phase, step, prebuffer flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      phase       <= '0;
      step        <= alr_pkg::STEP_RESET;
      prebuffered <= 1'b0;
    end else begin
      if (ram_we) begin
        count <= count + 1'b1;
      end
      if (cmd.bs_enter) begin
        prebuffered <= 1'b1;
      end
      if (cmd.step_nominal) begin
        step <= nominal;
      end
      if (cmd.step_write) begin
        step <= step_raw[alr_pkg::STEP_W] ? alr_pkg::STEP_MAX
                                          : step_raw[alr_pkg::STEP_W-1:0];
      end
      if (cmd.underrun) begin
        prebuffered <= 1'b0;
        phase       <= '0;
      end
      if (cmd.finish) begin
        head  <= head + alr_pkg::WIN_AW'(npop);
        count <= count - alr_pkg::CNT_W'(npop);
        phase <= adv[alr_pkg::PHASE_W-1:0];
      end
    end
  end

  // restoring divider, one quotient bit a cycle, top bit flags saturation
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= num;
      quo     <= '0;
      bit_idx <= alr_pkg::DIV_IW'(alr_pkg::DIV_QW - 1);
      neg     <= (fill_q < thr);
    end else if (cmd.div_iter) begin
      if (fits) begin
        rem          <= rem - trial[alr_pkg::NUM_W-1:0];
        quo[bit_idx] <= 1'b1;
      end
      bit_idx <= bit_idx - 1'b1;
    end
    if (cmd.mul) begin
      prod_step <= alr_pkg::PROD_W'(nominal) * alr_pkg::PROD_W'(factor);
    end
  end

  // interpolation pipeline and pending result
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_l <= rd_l;
      a_r <= rd_r;
    end
    if (cmd.cap_b) begin
      // a single held sample interpolates against itself
      if (count >= alr_pkg::CNT_W'(2)) begin
        b_l <= rd_l;
        b_r <= rd_r;
      end else begin
        b_l <= a_l;
        b_r <= a_r;
      end
    end
    if (cmd.interp) begin
      prod_l <= diff_l * frac;
      prod_r <= diff_r * frac;
    end
    if (cmd.silence) begin
      pend_left   <= '0;
      pend_right  <= '0;
      pend_status <= cmd.silence_code;
    end else if (cmd.finish) begin
      pend_left   <= mute_now ? '0 : to_pcm(sum_l);
      pend_right  <= mute_now ? '0 : to_pcm(sum_r);
      pend_status <= mute_now ? alr_pkg::ST_MUTED : alr_pkg::ST_NORMAL;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_left   <= pend_left;
      out_right  <= pend_right;
      out_status <= pend_status;
    end
  end

  always_comb begin
    stat.op          = op_q;
    stat.prebuffered = prebuffered;
    stat.empty       = (count == '0);
    stat.block_hold  = !prebuffered && (fill_q < thr);
    stat.thr_zero    = (thr == '0);
    stat.div_last    = (bit_idx == '0);
    stat.slot_free   = !out_valid || out_ready;
  end

endmodule

// ===== sv/adaptive_linear_resampler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_linear_resampler_core: adaptive rate stereo linear resampler
// ring window of source pairs, drift corrected step, interpolated pcm output
// ----------------------------------------------------------------------------
// usage
//   item: one request per handshake; push a Q2.15 stereo pair, block start
//     with upstream fill level, or output tick (with paused flag)
//   result: one pcm pair and status per output tick, none for other requests
//   cfg: register writes (nominal step, prebuffer threshold, correction limit,
//     mute on pause), always ready, to be written while the block is idle
// timing
//   one request at a time; ready is high only in the idle state
//   push: dispatch; silent tick: dispatch, emit; playing tick: dispatch,
//     capture a and b, interpolate, finish, emit; block start: dispatch,
//     then the restoring divider (one quotient bit per cycle), multiply and
//     step write if drift correction runs; result is registered on emit
// reset
//   synchronous rst empties the window, zeroes the phase, restores register
//   defaults and the nominal step, and re-enters prebuffering
// backpressure
//   the result register holds while the receiver stalls; the next request is
//   still taken, and a tick only waits if its result finds the register full
// ----------------------------------------------------------------------------
module adaptive_linear_resampler_core (
  input  logic clk,
  input  logic rst,
  alr_in_if.sink    item,
  alr_out_if.source result,
  alr_cfg_if.sink   cfg
);

  // command and status bundles between sequencer and datapath
  alr_pkg::cmd_t  cmd;
  alr_pkg::stat_t stat;

  // register writes never stall
  assign cfg.ready = 1'b1;

  // sequencer: dispatch, divider loop, interpolation steps, result hand-off
  alr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: window memory, phase/step state, divider, interpolator, output
  alr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (item.operation),
    .fill_level   (item.fill_level),
    .sample_left  (item.sample_left),
    .sample_right (item.sample_right),
    .paused       (item.paused),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_left     (result.out_left),
    .out_right    (result.out_right),
    .out_status   (result.status)
  );

endmodule
